// ===== rtl/numeric_literal_to_fixed16_core_defines.svh =====
// ----------------------------------------------------------------------------
// numeric literal parser assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_TO_FIXED16_CORE_DEFINES_SVH
`define NUMERIC_LITERAL_TO_FIXED16_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define NL2FX_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nl2fx same-cycle check failed");

// antecedent implies consequent in the next cycle
`define NL2FX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nl2fx next-cycle check failed");

`endif

// ===== rtl/nl2fx_pkg.sv =====
// ----------------------------------------------------------------------------
// nl2fx_pkg
// types, character codes and constants shared by the literal parser
// ----------------------------------------------------------------------------
package nl2fx_pkg;

	// default count of fraction digits that contribute
	localparam int FRAC_DIGITS_DEF = 8;

	// quotient bits of the fraction rounding divide (16 bits plus carry)
	localparam int DIV_STEPS = 17;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	// 'a' minus ten, maps a..f onto 10..15
	localparam logic [7:0] CH_HEX_OFS = 8'h57;

	// result kinds
	typedef enum logic [1:0] {
		KIND_NIL = 2'd0,
		KIND_INT = 2'd1,
		KIND_FIX = 2'd2
	} kind_t;

	// radix of the literal
	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2
	} radix_t;

	// parse phase
	typedef enum logic [4:0] {
		PH_LEAD  = 5'b00001,
		PH_START = 5'b00010,
		PH_BODY  = 5'b00100,
		PH_TRAIL = 5'b01000,
		PH_ERROR = 5'b10000
	} phase_t;

	// controller to datapath commands
	typedef struct packed {
		logic step;       // a character word is taken
		logic load_now;   // load nil or integer result from the final word
		logic div_start;  // load the rounding divider from the final word
		logic div_step;   // one quotient bit
		logic load_div;   // load fixed-point result from the divider
	} nl2fx_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic needs_div;  // current word would finish a valid literal with a dot
	} nl2fx_sts_t;

endpackage

// ===== rtl/nl2fx_if.sv =====
// ----------------------------------------------------------------------------
// nl2fx interfaces
// valid/ready channels for character words and result words
// ----------------------------------------------------------------------------
interface nl2fx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface nl2fx_out_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic signed [15:0] int_value;
	logic signed [31:0] fixed_value;

	modport source (output valid, output kind, output int_value, output fixed_value,
		input ready);
	modport sink (input valid, input kind, input int_value, input fixed_value,
		output ready);
endinterface

// ===== rtl/nl2fx_dp.sv =====
// ----------------------------------------------------------------------------
// nl2fx_dp
// parse state registers, rounding divider and result register
// ----------------------------------------------------------------------------
module nl2fx_dp
	import nl2fx_pkg::*;
#(
	parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	input  nl2fx_cmd_t         cmd,
	output nl2fx_sts_t         sts,
	output logic [1:0]         kind,
	output logic signed [15:0] int_value,
	output logic signed [31:0] fixed_value
);

	localparam int NUM_W   = 4 * FRAC_DIGITS;
	localparam int SCALE_W = NUM_W + 1;
	localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
	localparam int REM_W   = NUM_W + 18;

	// parse state
	phase_t               phase_q, phase_n;
	logic                 neg_q, neg_n;
	radix_t               radix_q, radix_n;
	logic                 zero_q, zero_n;
	logic [15:0]          acc_q, acc_n;
	logic                 dot_q, dot_n;
	logic [NUM_W-1:0]     num_q, num_n;
	logic [SCALE_W-1:0]   scale_q, scale_n;
	logic [CNT_W-1:0]     fcnt_q, fcnt_n;

	// divider and result
	logic [REM_W-1:0]     rem_q, dsh_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic                 neg_div_q;
	logic [15:0]          acc_div_q;
	kind_t                kind_q;
	logic [15:0]          int_q;
	logic [31:0]          fix_q;

	logic                 blank, do_body, at_start, dig_ok;
	logic [3:0]           dval;
	logic [18:0]          acc10;
	logic [NUM_W+2:0]     num10;
	logic [SCALE_W+2:0]   scale10;
	logic [REM_W:0]       diff;
	logic [31:0]          fix_raw;

	// whitespace class
	assign blank = (char_code == CH_SPACE) || (char_code == CH_LF) || (char_code == CH_CR) ||
		(char_code == CH_TAB) || (char_code == CH_FF) || (char_code == CH_VT);

	// digit value in the current radix
	always_comb begin
		dig_ok = 1'b0;
		dval   = 4'd0;
		if (radix_q == RADIX_BIN) begin
			dig_ok = (char_code == CH_0) || (char_code == CH_1);
			dval   = {3'b000, char_code[0]};
		end else if (char_code >= CH_0 && char_code <= CH_9) begin
			dig_ok = 1'b1;
			dval   = char_code[3:0];
		end else if (radix_q == RADIX_HEX && char_code >= CH_LC_A && char_code <= CH_LC_F) begin
			dig_ok = 1'b1;
			dval   = 4'(char_code - CH_HEX_OFS);
		end
	end

	// times ten as shift and add
	assign acc10   = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {15'd0, dval};
	assign num10   = {num_q, 3'b000} + {2'b00, num_q, 1'b0} + {{(NUM_W-1){1'b0}}, dval};
	assign scale10 = {scale_q, 3'b000} + {2'b00, scale_q, 1'b0};

	// next parse state for the current word
	always_comb begin
		phase_n  = phase_q;
		neg_n    = neg_q;
		radix_n  = radix_q;
		zero_n   = zero_q;
		acc_n    = acc_q;
		dot_n    = dot_q;
		num_n    = num_q;
		scale_n  = scale_q;
		fcnt_n   = fcnt_q;
		do_body  = 1'b0;
		at_start = 1'b0;
		unique case (phase_q)
			PH_LEAD: begin
				if (!blank) begin
					phase_n = PH_START;
					if (char_code == CH_MINUS) begin
						neg_n = 1'b1;
					end else begin
						do_body  = 1'b1;
						at_start = 1'b1;
					end
				end
			end
			PH_START, PH_BODY: begin
				if (blank) begin
					zero_n  = 1'b0;
					phase_n = PH_TRAIL;
				end else begin
					do_body  = 1'b1;
					at_start = (phase_q == PH_START);
				end
			end
			PH_TRAIL: begin
				if (!blank) phase_n = PH_ERROR;
			end
			default: begin
				phase_n = PH_ERROR;
			end
		endcase

		// non-blank character of the literal body
		if (do_body) begin
			zero_n  = 1'b0;
			phase_n = PH_BODY;
			if (zero_q && (char_code == CH_LC_X || char_code == CH_LC_B)) begin
				radix_n = (char_code == CH_LC_X) ? RADIX_HEX : RADIX_BIN;
			end else if (char_code == CH_DOT) begin
				if (dot_q) phase_n = PH_ERROR;
				else dot_n = 1'b1;
			end else if (!dig_ok) begin
				phase_n = PH_ERROR;
			end else if (!dot_q) begin
				unique case (radix_q)
					RADIX_HEX: acc_n = {acc_q[11:0], dval};
					RADIX_BIN: acc_n = {acc_q[14:0], dval[0]};
					default:   acc_n = acc10[15:0];
				endcase
				if (at_start && char_code == CH_0 && radix_q == RADIX_DEC) zero_n = 1'b1;
			end else if (fcnt_q < CNT_W'(FRAC_DIGITS)) begin
				unique case (radix_q)
					RADIX_HEX: begin
						num_n   = {num_q[NUM_W-5:0], dval};
						scale_n = {scale_q[SCALE_W-5:0], 4'b0000};
					end
					RADIX_BIN: begin
						num_n   = {num_q[NUM_W-2:0], dval[0]};
						scale_n = {scale_q[SCALE_W-2:0], 1'b0};
					end
					default: begin
						num_n   = num10[NUM_W-1:0];
						scale_n = scale10[SCALE_W-1:0];
					end
				endcase
				fcnt_n = fcnt_q + 1'b1;
			end
		end
	end

	assign sts.needs_div = (phase_n != PH_ERROR) && dot_n;

	// parse state, back to reset after the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			radix_q <= RADIX_DEC;
			zero_q  <= 1'b0;
			acc_q   <= '0;
			dot_q   <= 1'b0;
			num_q   <= '0;
			scale_q <= SCALE_W'(1);
			fcnt_q  <= '0;
		end else if (cmd.step) begin
			if (last_char) begin
				phase_q <= PH_LEAD;
				neg_q   <= 1'b0;
				radix_q <= RADIX_DEC;
				zero_q  <= 1'b0;
				acc_q   <= '0;
				dot_q   <= 1'b0;
				num_q   <= '0;
				scale_q <= SCALE_W'(1);
				fcnt_q  <= '0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				radix_q <= radix_n;
				zero_q  <= zero_n;
				acc_q   <= acc_n;
				dot_q   <= dot_n;
				num_q   <= num_n;
				scale_q <= scale_n;
				fcnt_q  <= fcnt_n;
			end
		end
	end

	// restoring divide of (num * 2^17 + scale) by (2 * scale)
	assign diff = {1'b0, rem_q} - {1'b0, dsh_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q     <= REM_W'({num_n, 17'd0}) + REM_W'(scale_n);
			dsh_q     <= {scale_n, 17'd0};
			quo_q     <= '0;
			neg_div_q <= neg_n;
			acc_div_q <= acc_n;
		end else if (cmd.div_step) begin
			if (!diff[REM_W]) rem_q <= diff[REM_W-1:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], !diff[REM_W]};
			dsh_q <= {1'b0, dsh_q[REM_W-1:1]};
		end
	end

	assign fix_raw = {acc_div_q, 16'd0} | {{(32-DIV_STEPS){1'b0}}, quo_q};

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			fix_q <= '0;
			if (phase_n == PH_ERROR) begin
				kind_q <= KIND_NIL;
				int_q  <= '0;
			end else begin
				kind_q <= KIND_INT;
				int_q  <= neg_n ? 16'(16'd0 - acc_n) : acc_n;
			end
		end else if (cmd.load_div) begin
			kind_q <= KIND_FIX;
			int_q  <= '0;
			fix_q  <= neg_div_q ? 32'(32'd0 - fix_raw) : fix_raw;
		end
	end

	assign kind        = kind_q;
	assign int_value   = int_q;
	assign fixed_value = fix_q;

endmodule

// ===== rtl/nl2fx_ctrl.sv =====
// ----------------------------------------------------------------------------
// nl2fx_ctrl
// word acceptance, divider sequencing and result valid
// ----------------------------------------------------------------------------
`include "numeric_literal_to_fixed16_core_defines.svh"

module nl2fx_ctrl
	import nl2fx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	input  nl2fx_sts_t sts,
	output nl2fx_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_DIV = 2'b10
	} ctrl_state_t;

	ctrl_state_t          state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
	logic                 out_valid_q, out_valid_d;
	logic                 out_free, accept;

	// result slot free now or emptied this cycle
	assign out_free = !out_valid_q || out_ready;
	// outside a divide, a final word waits for the result slot, others flow on
	assign in_ready = (state_q == ST_RUN) && (!in_last || out_free);
	assign accept   = in_valid && in_ready;

	// sequencing
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd.step      = 1'b0;
		cmd.load_now  = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.load_div  = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				cmd.step = accept;
				if (accept && in_last) begin
					if (sts.needs_div) begin
						cmd.div_start = 1'b1;
						cnt_d         = DIV_CNT_W'(DIV_STEPS);
						state_d       = ST_DIV;
					end else begin
						cmd.load_now = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (cnt_q != '0) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q - 1'b1;
				end else if (out_free) begin
					cmd.load_div = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// result valid
	assign out_valid_d = (cmd.load_now || cmd.load_div) ? 1'b1 : (out_valid_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`NL2FX_ASSERT_SAME(a_no_accept_in_div, state_q == ST_DIV, !in_ready)
	`NL2FX_ASSERT_SAME(a_load_needs_slot, cmd.load_now || cmd.load_div, out_free)
	`NL2FX_ASSERT_NEXT(a_div_start_count, cmd.div_start,
		state_q == ST_DIV && cnt_q == DIV_CNT_W'(DIV_STEPS))
	`NL2FX_ASSERT_NEXT(a_div_count_down, state_q == ST_DIV && cnt_q != '0,
		cnt_q == DIV_CNT_W'($past(cnt_q) - 1'b1))

endmodule

// ===== rtl/numeric_literal_to_fixed16_core.sv =====
// ----------------------------------------------------------------------------
// numeric_literal_to_fixed16_core
// streaming numeric literal parser, integer or q16.16 result
// ----------------------------------------------------------------------------
// Takes a literal one character word per cycle, last_char on the final one,
// and gives one result word per literal: nil, a 16-bit integer, or a Q16.16
// value for literals with a dot. Leading and trailing whitespace, one leading
// minus, and 0x (lower-case hex) or 0b prefixes are handled. An integer or
// nil result is registered as the final character is taken and is valid in
// the cycle after. A fixed-point result passes through a restoring divider
// that rounds the fraction, one quotient bit per cycle, and is then loaded
// once the result register is free; no character is taken meanwhile.
// Characters keep flowing while a result waits to be taken; only a final
// character waits for the result register to free up.
module numeric_literal_to_fixed16_core
	import nl2fx_pkg::*;
#(
	parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	nl2fx_in_if.sink    lit,
	nl2fx_out_if.source res
);

	nl2fx_cmd_t cmd;
	nl2fx_sts_t sts;
	logic       in_ready, out_valid;

	nl2fx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lit.valid),
		.in_last   (lit.last_char),
		.in_ready  (in_ready),
		.out_ready (res.ready),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	nl2fx_dp #(
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (lit.char_code),
		.last_char   (lit.last_char),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (res.kind),
		.int_value   (res.int_value),
		.fixed_value (res.fixed_value)
	);

	assign lit.ready = in_ready;
	assign res.valid = out_valid;

endmodule

// ===== tb/literal_value_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_value_check
// watches the character and result channels, predicts each literal's value
// and compares every result word field by field in arrival order
// ----------------------------------------------------------------------------
module literal_value_check
	import nl2fx_pkg::*;
#(
	parameter int FRAC_LIMIT = FRAC_DIGITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	nl2fx_in_if  lit,
	nl2fx_out_if res,
	output int   fail_count,
	output int   awaiting
);

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] int_val;
		logic signed [31:0] fix_val;
	} literal_result_t;

	// predicted values still waiting for their result word
	literal_result_t expected_values[$];
	int mismatch_total;

	// parse state of the literal in flight
	phase_t      ph;
	logic        neg;
	radix_t      rdx;
	logic        lead_zero;
	logic [15:0] int_acc;
	logic        dot;
	logic [63:0] frac_num;
	logic [63:0] frac_scale;
	int          frac_cnt;

	function automatic logic blank_char(input logic [7:0] c);
		return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB ||
			c == CH_FF || c == CH_VT;
	endfunction

	// digit value in the given radix, -1 when not a digit
	function automatic int digit_in_radix(input logic [7:0] c, input radix_t r);
		if (r == RADIX_BIN) begin
			return (c == CH_0 || c == CH_1) ? int'(c) - int'(CH_0) : -1;
		end
		if (c >= CH_0 && c <= CH_9) begin
			return int'(c) - int'(CH_0);
		end
		if (r == RADIX_HEX && c >= CH_LC_A && c <= CH_LC_F) begin
			return int'(c) - int'(CH_HEX_OFS);
		end
		return -1;
	endfunction

	function automatic int radix_base(input radix_t r);
		case (r)
			RADIX_HEX: return 16;
			RADIX_BIN: return 2;
			default:   return 10;
		endcase
	endfunction

	function void clear_parse();
		ph = PH_LEAD;
		neg = 1'b0;
		rdx = RADIX_DEC;
		lead_zero = 1'b0;
		int_acc = '0;
		dot = 1'b0;
		frac_num = '0;
		frac_scale = 64'd1;
		frac_cnt = 0;
	endfunction

	// non-blank character once the literal has started
	function void take_body_char(input logic [7:0] c);
		logic at_start;
		logic zero_before;
		int   d;
		at_start = (ph == PH_START);
		zero_before = lead_zero;
		lead_zero = 1'b0;
		ph = PH_BODY;
		// prefix letter right after a lone leading zero
		if (zero_before && (c == CH_LC_X || c == CH_LC_B)) begin
			rdx = (c == CH_LC_X) ? RADIX_HEX : RADIX_BIN;
			return;
		end
		if (c == CH_DOT) begin
			if (dot) ph = PH_ERROR;
			else dot = 1'b1;
			return;
		end
		d = digit_in_radix(c, rdx);
		if (d < 0) begin
			ph = PH_ERROR;
			return;
		end
		if (!dot) begin
			case (rdx)
				RADIX_HEX: int_acc = {int_acc[11:0], 4'(d)};
				RADIX_BIN: int_acc = {int_acc[14:0], 1'(d)};
				default:   int_acc = 16'(int_acc * 10 + d);
			endcase
			if (at_start && c == CH_0 && rdx == RADIX_DEC) lead_zero = 1'b1;
		end else if (frac_cnt < FRAC_LIMIT) begin
			// digits past the limit are checked but add nothing
			frac_num = frac_num * radix_base(rdx) + d;
			frac_scale = frac_scale * radix_base(rdx);
			frac_cnt++;
		end
	endfunction

	// value of the finished literal
	function literal_result_t finish_literal();
		literal_result_t r;
		logic [63:0] rounded;
		logic [31:0] fx;
		r.kind = KIND_NIL;
		r.int_val = '0;
		r.fix_val = '0;
		if (ph != PH_ERROR) begin
			if (!dot) begin
				r.kind = KIND_INT;
				r.int_val = neg ? -int_acc : int_acc;
			end else begin
				// round half up of fraction * 65536, carry lands in bit 16
				rounded = (frac_num * 64'd131072 + frac_scale) / (64'd2 * frac_scale);
				fx = {int_acc, 16'h0000} | rounded[31:0];
				r.kind = KIND_FIX;
				r.fix_val = neg ? -fx : fx;
			end
		end
		return r;
	endfunction

	function void take_char(input logic [7:0] c, input logic last);
		case (ph)
			PH_LEAD: begin
				if (blank_char(c)) begin
				end else if (c == CH_MINUS) begin
					neg = 1'b1;
					ph = PH_START;
				end else begin
					ph = PH_START;
					take_body_char(c);
				end
			end
			PH_START, PH_BODY: begin
				if (blank_char(c)) begin
					lead_zero = 1'b0;
					ph = PH_TRAIL;
				end else begin
					take_body_char(c);
				end
			end
			PH_TRAIL: begin
				if (!blank_char(c)) ph = PH_ERROR;
			end
			default: ph = PH_ERROR;
		endcase
		if (last) begin
			expected_values.push_back(finish_literal());
			clear_parse();
		end
	endfunction

	// compare one result word with the oldest prediction
	function void check_result();
		literal_result_t e;
		if (expected_values.size() == 0) begin
			$error("result word with no literal pending: kind %0d", res.kind);
			mismatch_total++;
			return;
		end
		e = expected_values.pop_front();
		if (res.kind !== e.kind) begin
			$error("kind: expected %0d, actual %0d", e.kind, res.kind);
			mismatch_total++;
		end
		if (res.int_value !== e.int_val) begin
			$error("int_value: expected %0d, actual %0d", e.int_val, res.int_value);
			mismatch_total++;
		end
		if (res.fixed_value !== e.fix_val) begin
			$error("fixed_value: expected 0x%08h, actual 0x%08h", e.fix_val,
				res.fixed_value);
			mismatch_total++;
		end
	endfunction

	// sample both channels on the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			expected_values.delete();
			mismatch_total = 0;
			fail_count <= 0;
			awaiting <= 0;
		end else begin
			if (res.valid && res.ready) check_result();
			if (lit.valid && lit.ready) take_char(lit.char_code, lit.last_char);
			fail_count <= mismatch_total;
			awaiting <= expected_values.size();
		end
	end

endmodule

// ===== tb/numeric_literal_to_fixed16_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_to_fixed16_core_test
// drives literals through the parser, directed corner cases first and then
// random well-formed and broken literals, with bursty input and a stalling
// result side; the checker module predicts and compares every result word
// ----------------------------------------------------------------------------
module numeric_literal_to_fixed16_core_test;
	import nl2fx_pkg::*;

	localparam int RANDOM_CHARS = 960;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 30;
	localparam int HOLD_CYCLES  = 150;
	localparam logic [7:0] CASE_GAP = 8'h20;

	typedef logic [7:0] char_queue_t [$];

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE
	} rx_style_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   awaiting;
	int   chars_sent;
	int   burst_left;
	int   idle_cycles;

	nl2fx_in_if  lit ();
	nl2fx_out_if res ();

	numeric_literal_to_fixed16_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.lit    (lit),
		.res    (res)
	);

	literal_value_check monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.lit        (lit),
		.res        (res),
		.fail_count (fail_count),
		.awaiting   (awaiting)
	);

	// corner cases: extremes, prefixes, empty parts, rounding and every way to nil
	string directed_lits [$] = '{
		" 42 ", "-7", "70000", "0x7fff", "-0x8000", "0b1011", "3.5", "-3.25",
		".", "5.", ".5", "\011\012\013\014\015 ", "-", "0x", "0b",
		"0.99999999", "1.123456789", "0x.ffffffff", "0b1.11111111",
		"1 2", "1..2", "--1", "1-", "0xAB", "00x1", "\377", "0b102",
		"32767.99999", "-32768.5"
	};

	logic [7:0] blank_set [6] = '{CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_FF, CH_VT};

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [7:0] random_blank();
		return blank_set[$urandom_range(0, 5)];
	endfunction

	function automatic logic [7:0] random_digit(input radix_t r);
		int d;
		case (r)
			RADIX_HEX: begin
				d = $urandom_range(0, 15);
				return (d < 10) ? CH_0 + 8'(d) : CH_LC_A + 8'(d - 10);
			end
			RADIX_BIN: return CH_0 + 8'($urandom_range(0, 1));
			default:   return CH_0 + 8'($urandom_range(0, 9));
		endcase
	endfunction

	// mostly well-formed literals with random content, some broken, some noise
	function automatic char_queue_t random_literal();
		char_queue_t q;
		radix_t      r;
		int          n;
		int          pick;
		int          pos;
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		repeat ($urandom_range(0, 2)) q.push_back(random_blank());
		if ($urandom_range(0, 3) == 0) q.push_back(CH_MINUS);
		pick = $urandom_range(0, 9);
		r = (pick < 6) ? RADIX_DEC : (pick < 8) ? RADIX_HEX : RADIX_BIN;
		if (r == RADIX_HEX) begin
			q.push_back(CH_0);
			q.push_back(CH_LC_X);
		end else if (r == RADIX_BIN) begin
			q.push_back(CH_0);
			q.push_back(CH_LC_B);
		end
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 18) : $urandom_range(0, 3);
		repeat (n) q.push_back(random_digit(r));
		if ($urandom_range(0, 1) == 1) begin
			q.push_back(CH_DOT);
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 4);
			repeat (n) q.push_back(random_digit(r));
		end
		repeat ($urandom_range(0, 2)) q.push_back(random_blank());
		if (q.size() == 0) q.push_back(random_digit(r));
		// damage about one literal in six
		if ($urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, q.size() - 1);
			case ($urandom_range(0, 3))
				0: q[pos] = 8'($urandom_range(0, 255));
				1: q.insert(pos, random_blank());
				2: q.insert(pos, ($urandom_range(0, 1) == 1) ? CH_DOT : CH_MINUS);
				default: q.insert(pos, CH_LC_A - CASE_GAP + 8'($urandom_range(0, 5)));
			endcase
		end
		return q;
	endfunction

	function automatic char_queue_t text_to_chars(input string s);
		char_queue_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// send one literal, a word per character, in bursts with random gaps
	task automatic send_literal(input char_queue_t chars);
		for (int i = 0; i < chars.size(); i++) begin
			lit.valid <= 1'b1;
			lit.char_code <= chars[i];
			lit.last_char <= (i == chars.size() - 1);
			do @(posedge clk); while (!lit.ready);
			chars_sent++;
			burst_left--;
			if (burst_left <= 0) begin
				if ($urandom_range(0, 3) != 0) begin
					lit.valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		lit.valid = 1'b0;
		lit.char_code = '0;
		lit.last_char = 1'b0;
		burst_left = $urandom_range(1, 40);
		chars_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_lits[i]) send_literal(text_to_chars(directed_lits[i]));
		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS) send_literal(random_literal());
		lit.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("numeric_literal_to_fixed16_core: match");
		end else begin
			$display("numeric_literal_to_fixed16_core: mismatch");
		end
		$finish;
	end

	// result side stalls in segments of random style, with two long hold-offs
	initial begin
		rx_style_t style;
		int        seg_left;
		int        hold_left;
		int        cycle_no;
		res.ready = 1'b0;
		seg_left = 0;
		hold_left = 0;
		cycle_no = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no == 400 || cycle_no == 1800) hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					style = rx_style_t'($urandom_range(0, 2));
					seg_left = $urandom_range(10, 60);
				end
				seg_left--;
				case (style)
					RX_OPEN: res.ready <= 1'b1;
					RX_COIN: res.ready <= 1'($urandom_range(0, 1));
					default: res.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((lit.valid && lit.ready) || (res.valid && res.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("numeric_literal_to_fixed16_core: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial idle_cycles = 0;

endmodule
